FILE: design/cc2_pkg.sv
// ----------------------------------------------------------------------------
// cc2_pkg
// Shared types and constants for the two-detector coincidence counter.
// ----------------------------------------------------------------------------
package cc2_pkg;

  // detector masks of an open group
  localparam logic [1:0] DET_MASK_1    = 2'b01;
  localparam logic [1:0] DET_MASK_2    = 2'b10;
  localparam logic [1:0] DET_MASK_BOTH = 2'b11;

  // adjusted times carry this offset so they never go negative
  localparam int DELAY_BIAS_BIT = 21;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 21;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DET1_LOW  = 3'd0,
    REG_DET1_HIGH = 3'd1,
    REG_DET2_LOW  = 3'd2,
    REG_DET2_HIGH = 3'd3,
    REG_WINDOW    = 3'd4,
    REG_DET1_DLY  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] det1_low;
    logic [15:0] det1_high;
    logic [15:0] det2_low;
    logic [15:0] det2_high;
    logic [19:0] window;
    logic [20:0] det1_delay;
  } cfg_t;

  // classification of one queued item
  typedef struct packed {
    logic frame_end;
    logic det;
    logic keep;
  } item_flags_t;

endpackage

FILE: design/cc2_front.sv
// ----------------------------------------------------------------------------
// cc2_front
// Accepts beats, applies the energy window and forms the biased adjusted time.
// ----------------------------------------------------------------------------
module cc2_front import cc2_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((TIME_BITS+32+7)/8)*8-1:0]    s_tdata,  // event_time, energy, dead_time
  input  logic [1:0]                           s_tuser,  // action, detector
  input  cfg_t                                 cfg,
  input  logic                                 q_full,
  output logic                                 push,
  output item_flags_t                          flags,
  output logic [TIME_BITS+1:0]                 adj,
  output logic [15:0]                          dead
);

  localparam int AW = TIME_BITS + 2;

  logic [TIME_BITS-1:0] t;
  logic [15:0]          energy;
  logic [15:0]          lo;
  logic [15:0]          hi;
  logic [AW-1:0]        bias;
  logic [AW-1:0]        delay_ext;

  assign t      = s_tdata[TIME_BITS-1:0];
  assign energy = s_tdata[TIME_BITS+15:TIME_BITS];
  assign dead   = s_tdata[TIME_BITS+31:TIME_BITS+16];

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  assign lo = s_tuser[1] ? cfg.det2_low  : cfg.det1_low;
  assign hi = s_tuser[1] ? cfg.det2_high : cfg.det1_high;

  assign bias      = AW'(1) << DELAY_BIAS_BIT;
  assign delay_ext = s_tuser[1] ? '0 : {{(AW-21){cfg.det1_delay[20]}}, cfg.det1_delay};

  // result is never negative, so the wrap of the sum is harmless
  assign adj = {2'b00, t} + bias + delay_ext;

  assign flags.frame_end = s_tuser[0];
  assign flags.det       = s_tuser[1];
  assign flags.keep      = (energy > lo) && (energy <= hi);

endmodule

FILE: design/cc2_queue.sv
// ----------------------------------------------------------------------------
// cc2_queue
// Short register queue between the classify front and the counting back.
// ----------------------------------------------------------------------------
module cc2_queue import cc2_pkg::*; #(
  parameter int WIDTH = 69
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/cc2_back.sv
// ----------------------------------------------------------------------------
// cc2_back
// Groups kept events, keeps the frame counters and drives the result beat.
// ----------------------------------------------------------------------------
module cc2_back import cc2_pkg::*; #(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  item_flags_t          q_flags,
  input  logic [TIME_BITS+1:0] q_adj,
  input  logic [15:0]          q_dead,
  output logic                 q_pop,
  input  logic [19:0]          window,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // det1_count, det2_count, single_coincidences, multiple_coincidences,
  // det1_dead_sum, det2_dead_sum
  output logic [191:0]         m_tdata
);

  localparam int AW = TIME_BITS + 2;
  localparam int CW = COUNT_BITS;

  logic [AW-1:0] group_last_time;
  logic [1:0]    group_detectors;
  logic [1:0]    group_size;
  logic [CW-1:0] win1;
  logic [CW-1:0] win2;
  logic [CW-1:0] single_cnt;
  logic [CW-1:0] multi_cnt;
  logic [CW-1:0] dead1;
  logic [CW-1:0] dead2;

  logic          is_frame;
  logic [AW-1:0] gap;
  logic          in_win;
  logic          join_grp;
  logic          close_en;
  logic          coinc_hit;
  logic [CW-1:0] single_next;
  logic [CW-1:0] multi_next;
  logic [1:0]    det_bit;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [15:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {{(CW+1-16){1'b0}}, b};
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  function automatic logic [31:0] out32(input logic [CW-1:0] a);
    logic [CW+31:0] w;
    w = {32'd0, a};
    return w[31:0];
  endfunction

  assign is_frame = q_flags.frame_end;
  assign q_pop    = q_valid && (!is_frame || !m_tvalid || m_tready);

  // a negative gap always joins an open group
  assign gap      = q_adj - group_last_time;
  assign in_win   = (q_adj < group_last_time) || (gap <= {{(AW-20){1'b0}}, window});
  assign join_grp = (group_size != 2'd0) && in_win;

  assign close_en  = is_frame || (q_flags.keep && !join_grp);
  assign coinc_hit = close_en && (group_size >= 2'd2) && (group_detectors == DET_MASK_BOTH);

  assign single_next = (coinc_hit && group_size == 2'd2) ? sat_add(single_cnt, 16'd1)
                                                         : single_cnt;
  assign multi_next  = (coinc_hit && group_size == 2'd3) ? sat_add(multi_cnt, 16'd1)
                                                         : multi_cnt;
  assign det_bit     = q_flags.det ? DET_MASK_2 : DET_MASK_1;

  always_ff @(posedge clk) begin
    if (q_pop && is_frame) begin
      m_tdata <= {out32(dead2), out32(dead1), out32(multi_next), out32(single_next),
                  out32(win2), out32(win1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid        <= 1'b0;
      group_last_time <= '0;
      group_detectors <= '0;
      group_size      <= '0;
      win1            <= '0;
      win2            <= '0;
      single_cnt      <= '0;
      multi_cnt       <= '0;
      dead1           <= '0;
      dead2           <= '0;
    end else begin
      if (q_pop && is_frame) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_pop) begin
        if (is_frame) begin
          group_last_time <= '0;
          group_detectors <= '0;
          group_size      <= '0;
          win1            <= '0;
          win2            <= '0;
          single_cnt      <= '0;
          multi_cnt       <= '0;
          dead1           <= '0;
          dead2           <= '0;
        end else begin
          if (q_flags.det) begin
            dead2 <= sat_add(dead2, q_dead);
          end else begin
            dead1 <= sat_add(dead1, q_dead);
          end
          if (q_flags.keep) begin
            if (q_flags.det) begin
              win2 <= sat_add(win2, 16'd1);
            end else begin
              win1 <= sat_add(win1, 16'd1);
            end
            single_cnt      <= single_next;
            multi_cnt       <= multi_next;
            group_last_time <= q_adj;
            if (join_grp) begin
              group_detectors <= group_detectors | det_bit;
              group_size      <= (group_size == 2'd3) ? 2'd3 : group_size + 2'd1;
            end else begin
              group_detectors <= det_bit;
              group_size      <= 2'd1;
            end
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    (q_pop && is_frame) |=> (m_tvalid && group_size == 2'd0 && win1 == '0 && win2 == '0))
    else $error("frame end did not post a result and clear the group");

  a_group_has_det: assert property (@(posedge clk) disable iff (rst)
    (group_size != 2'd0) |-> (group_detectors != 2'd0))
    else $error("open group without a detector");

  a_single_member: assert property (@(posedge clk) disable iff (rst)
    (group_size == 2'd1) |-> $onehot(group_detectors))
    else $error("one-event group marks both detectors");
`endif

endmodule

FILE: design/two_detector_coincidence_counter.sv
// flow: an event beat lands in the queue at the next edge; a frame-end beat passes
//   through the queue register and then raises the registered m_tvalid and m_tdata
// throughput: one beat per cycle while the queue is not full;
//   a frame-end beat waits in the queue while the previous result is not taken
// reset: synchronous rst clears queue, counters and group state and loads the
//   register defaults
// ----------------------------------------------------------------------------
// two_detector_coincidence_counter
// Per-frame in-window counts, coincidence counts and dead-time sums for two
// detectors with an extending coincidence window.
// ----------------------------------------------------------------------------
module two_detector_coincidence_counter import cc2_pkg::*; #(
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((TIME_BITS+32+7)/8)*8-1:0] s_tdata,  // event_time, energy, dead_time
  input  logic [1:0]                        s_tuser,  // action, detector
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // det1_count, det2_count, single_coincidences, multiple_coincidences,
  // det1_dead_sum, det2_dead_sum
  output logic [191:0]                      m_tdata,
  input  logic                              cfg_we,
  input  logic [CFG_ADDR_W-1:0]             cfg_addr,
  input  logic [CFG_DATA_W-1:0]             cfg_data
);

  localparam int AW = TIME_BITS + 2;
  localparam int QW = $bits(item_flags_t) + 16 + AW;

  cfg_t          cfg;
  logic          push;
  item_flags_t   f_flags;
  logic [AW-1:0] f_adj;
  logic [15:0]   f_dead;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic [QW-1:0] q_data;
  item_flags_t   q_flags;
  logic [AW-1:0] q_adj;
  logic [15:0]   q_dead;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.det1_low   <= 16'd1;
      cfg.det1_high  <= 16'd4095;
      cfg.det2_low   <= 16'd1;
      cfg.det2_high  <= 16'd4095;
      cfg.window     <= 20'd100;
      cfg.det1_delay <= 21'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DET1_LOW:  cfg.det1_low   <= cfg_data[15:0];
        REG_DET1_HIGH: cfg.det1_high  <= cfg_data[15:0];
        REG_DET2_LOW:  cfg.det2_low   <= cfg_data[15:0];
        REG_DET2_HIGH: cfg.det2_high  <= cfg_data[15:0];
        REG_WINDOW:    cfg.window     <= cfg_data[19:0];
        REG_DET1_DLY:  cfg.det1_delay <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  cc2_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .flags    (f_flags),
    .adj      (f_adj),
    .dead     (f_dead)
  );

  cc2_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_flags, f_dead, f_adj}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  assign q_adj   = q_data[AW-1:0];
  assign q_dead  = q_data[AW+15:AW];
  assign q_flags = item_flags_t'(q_data[QW-1:AW+16]);

  cc2_back #(
    .COUNT_BITS(COUNT_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_flags  (q_flags),
    .q_adj    (q_adj),
    .q_dead   (q_dead),
    .q_pop    (q_pop),
    .window   (cfg.window),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
